FILE: rtl/core/acpc_pkg.sv
// Shared constants, codes and types for the Aho-Corasick pattern counter.
// Used by the shared add unit and the top level; no dependencies.
`default_nettype none
package acpc_pkg;

    localparam int NODE_CAP  = 65536;
    localparam int NODE_W    = $clog2(NODE_CAP);
    localparam int TOTAL_W   = NODE_W + 1;
    localparam int ALPHA     = 26;
    localparam int SYM_W     = $clog2(ALPHA);
    localparam int GOTO_AW   = NODE_W + SYM_W;
    localparam int COUNT_W   = 16;
    localparam logic [7:0] FIRST_SYM = 8'h61;

    // operation codes
    localparam logic [2:0] OP_PAT_CHAR = 3'd0;
    localparam logic [2:0] OP_PAT_END  = 3'd1;
    localparam logic [2:0] OP_BUILD    = 3'd2;
    localparam logic [2:0] OP_TXT_CHAR = 3'd3;
    localparam logic [2:0] OP_TXT_END  = 3'd4;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_BAD   = 2'd2,
        ST_ORDER = 2'd3
    } status_t;

    // request to the shared adder
    typedef struct packed {
        logic [TOTAL_W-1:0] a;
        logic [TOTAL_W-1:0] b;
        logic               sat;
    } add_req_t;

endpackage
`default_nettype wire

FILE: rtl/core/aho_corasick_pattern_counter.sv
// Aho-Corasick pattern counter: usage notes.
// Input words on s_*: tdata[2:0] operation, tdata[10:3] symbol. Pattern chars
// grow the trie, pattern end bumps the end count, build sets failure links,
// text chars step the automaton, text end reports the count for that text.
// Exactly one result word per input word on m_*: tdata[15:0] match_count,
// tdata[17:16] status. One word is worked on at a time; s_tready is low
// until its result is handed to the output register, and after a text end
// until the visited marks are cleared. Text chars walk the unvisited part
// of the failure chain, stopping at a visited node or the root; text end
// sweeps all visited marks; build walks the trie breadth-first over the
// goto memory (one read port), visiting every node, root included. Bad or
// out-of-order words go straight to their result.
// After reset a clearing pass zeroes the goto, link, count and mark
// memories; s_tready stays low meanwhile.
// A stalled receiver holds the result in the output register; the next
// word can be accepted meanwhile, its result waits for the register.
`default_nettype none
module aho_corasick_pattern_counter
    import acpc_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // [2:0] operation, [10:3] symbol
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata    // [15:0] match_count, [17:16] status
);

    typedef enum logic [17:0] {
        S_CLEAR  = 18'h00001,
        S_IDLE   = 18'h00002,
        S_PC_RD  = 18'h00004,
        S_PC_CHK = 18'h00008,
        S_PE_RD  = 18'h00010,
        S_PE_WR  = 18'h00020,
        S_B_RD   = 18'h00040,
        S_B_RC   = 18'h00080,
        S_B_RB   = 18'h00100,
        S_B_POP  = 18'h00200,
        S_B_NODE = 18'h00400,
        S_B_BACK = 18'h00800,
        S_T_RD   = 18'h01000,
        S_T_NXT  = 18'h02000,
        S_T_CHK  = 18'h04000,
        S_T_EVAL = 18'h08000,
        S_RESP   = 18'h10000,
        S_VCLR   = 18'h20000
    } state_t;

    state_t state_reg, state_next;

    logic [GOTO_AW-1:0] clr_reg, clr_next;
    logic [TOTAL_W-1:0] node_total_reg, node_total_next;
    logic [NODE_W-1:0]  ins_reg, ins_next;
    status_t            dropped_reg, dropped_next;
    logic               built_reg, built_next;
    logic [NODE_W-1:0]  cur_reg, cur_next;
    logic [COUNT_W-1:0] hit_reg, hit_next;
    logic [SYM_W-1:0]   sym_reg, sym_next;
    status_t            status_reg, status_next;
    logic               vclr_reg, vclr_next;
    logic [NODE_W-1:0]  j_reg, j_next;
    logic [NODE_W-1:0]  node_reg, node_next;
    logic [NODE_W-1:0]  back_reg, back_next;
    logic [NODE_W-1:0]  child_reg, child_next;
    logic [SYM_W-1:0]   c_reg, c_next;
    logic               root_reg, root_next;
    logic [TOTAL_W-1:0] head_reg, head_next;
    logic [TOTAL_W-1:0] tail_reg, tail_next;
    logic               m_valid_reg, m_valid_next;
    logic [17:0]        m_data_reg, m_data_next;

    // memory ports
    logic               g_we, f_we, e_we, v_we, q_we;
    logic [GOTO_AW-1:0] g_waddr, g_raddr;
    logic [NODE_W-1:0]  g_wdata, g_rdata;
    logic [NODE_W-1:0]  f_waddr, f_raddr, f_wdata, f_rdata;
    logic [NODE_W-1:0]  e_waddr, e_raddr;
    logic [COUNT_W-1:0] e_wdata, e_rdata;
    logic [NODE_W-1:0]  v_waddr, v_raddr;
    logic               v_wdata, v_rdata;
    logic [NODE_W-1:0]  q_waddr, q_raddr, q_wdata, q_rdata;

    add_req_t           add_req;
    logic [TOTAL_W-1:0] add_sum;

    // input decode
    logic [2:0] op_in;
    logic [7:0] sym_raw;
    logic [7:0] sym_off;
    logic       sym_ok;

    assign op_in   = s_tdata[2:0];
    assign sym_raw = s_tdata[10:3];
    assign sym_off = sym_raw - FIRST_SYM;
    assign sym_ok  = (sym_raw >= FIRST_SYM) && (sym_off < 8'(ALPHA));

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {6'd0, m_data_reg};

    acpc_add u_add (
        .req (add_req),
        .sum (add_sum)
    );

    acpc_ram #(.WIDTH(NODE_W), .DEPTH(1 << GOTO_AW)) u_goto (
        .aclk (aclk), .we (g_we), .waddr (g_waddr), .wdata (g_wdata),
        .raddr (g_raddr), .rdata (g_rdata)
    );

    acpc_ram #(.WIDTH(NODE_W), .DEPTH(NODE_CAP)) u_fail (
        .aclk (aclk), .we (f_we), .waddr (f_waddr), .wdata (f_wdata),
        .raddr (f_raddr), .rdata (f_rdata)
    );

    acpc_ram #(.WIDTH(COUNT_W), .DEPTH(NODE_CAP)) u_endc (
        .aclk (aclk), .we (e_we), .waddr (e_waddr), .wdata (e_wdata),
        .raddr (e_raddr), .rdata (e_rdata)
    );

    acpc_ram #(.WIDTH(1), .DEPTH(NODE_CAP)) u_vis (
        .aclk (aclk), .we (v_we), .waddr (v_waddr), .wdata (v_wdata),
        .raddr (v_raddr), .rdata (v_rdata)
    );

    acpc_ram #(.WIDTH(NODE_W), .DEPTH(NODE_CAP)) u_queue (
        .aclk (aclk), .we (q_we), .waddr (q_waddr), .wdata (q_wdata),
        .raddr (q_raddr), .rdata (q_rdata)
    );

    // sequencer
    always_comb begin
        state_next      = state_reg;
        clr_next        = clr_reg;
        node_total_next = node_total_reg;
        ins_next        = ins_reg;
        dropped_next    = dropped_reg;
        built_next      = built_reg;
        cur_next        = cur_reg;
        hit_next        = hit_reg;
        sym_next        = sym_reg;
        status_next     = status_reg;
        vclr_next       = vclr_reg;
        j_next          = j_reg;
        node_next       = node_reg;
        back_next       = back_reg;
        child_next      = child_reg;
        c_next          = c_reg;
        root_next       = root_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        m_data_next     = m_data_reg;
        m_valid_next    = m_valid_reg && !m_tready;

        g_we = 1'b0; g_waddr = '0; g_wdata = '0; g_raddr = '0;
        f_we = 1'b0; f_waddr = '0; f_wdata = '0; f_raddr = '0;
        e_we = 1'b0; e_waddr = '0; e_wdata = '0; e_raddr = '0;
        v_we = 1'b0; v_waddr = '0; v_wdata = 1'b0; v_raddr = '0;
        q_we = 1'b0; q_waddr = '0; q_wdata = '0; q_raddr = '0;
        add_req = '0;

        unique case (state_reg)
            // zero goto, link, count and mark stores after reset
            S_CLEAR: begin
                g_we    = 1'b1;
                g_waddr = clr_reg;
                f_we    = 1'b1;
                f_waddr = clr_reg[NODE_W-1:0];
                e_we    = 1'b1;
                e_waddr = clr_reg[NODE_W-1:0];
                v_we    = 1'b1;
                v_waddr = clr_reg[NODE_W-1:0];
                clr_next = clr_reg + 1'b1;
                if (&clr_reg) begin
                    state_next = S_IDLE;
                end
            end

            // take a word and dispatch
            S_IDLE: begin
                if (s_tvalid) begin
                    sym_next    = sym_off[SYM_W-1:0];
                    status_next = ST_OK;
                    vclr_next   = 1'b0;
                    state_next  = S_RESP;
                    unique case (op_in)
                        OP_PAT_CHAR: begin
                            if (built_reg) begin
                                status_next = ST_ORDER;
                            end else if (dropped_reg != ST_OK) begin
                                status_next = dropped_reg;
                            end else if (!sym_ok) begin
                                dropped_next = ST_BAD;
                                status_next  = ST_BAD;
                            end else begin
                                state_next = S_PC_RD;
                            end
                        end
                        OP_PAT_END: begin
                            if (built_reg) begin
                                status_next = ST_ORDER;
                            end else if (dropped_reg != ST_OK) begin
                                status_next  = dropped_reg;
                                ins_next     = '0;
                                dropped_next = ST_OK;
                            end else begin
                                state_next = S_PE_RD;
                            end
                        end
                        OP_BUILD: begin
                            if (built_reg) begin
                                status_next = ST_ORDER;
                            end else begin
                                node_next  = '0;
                                back_next  = '0;
                                root_next  = 1'b1;
                                c_next     = '0;
                                head_next  = '0;
                                tail_next  = '0;
                                state_next = S_B_RD;
                            end
                        end
                        OP_TXT_CHAR: begin
                            if (!built_reg) begin
                                status_next = ST_ORDER;
                            end else if (!sym_ok) begin
                                status_next = ST_BAD;
                                cur_next    = '0;
                            end else begin
                                state_next = S_T_RD;
                            end
                        end
                        OP_TXT_END: begin
                            if (!built_reg) begin
                                status_next = ST_ORDER;
                            end else begin
                                vclr_next = 1'b1;
                            end
                        end
                        default: begin
                            status_next = ST_ORDER;
                        end
                    endcase
                end
            end

            // pattern char: look up edge, add node if missing
            S_PC_RD: begin
                g_raddr    = {ins_reg, sym_reg};
                state_next = S_PC_CHK;
            end
            S_PC_CHK: begin
                add_req.a   = node_total_reg;
                add_req.b   = TOTAL_W'(1);
                add_req.sat = 1'b0;
                state_next  = S_RESP;
                if (g_rdata != '0) begin
                    ins_next = g_rdata;
                end else if (node_total_reg >= TOTAL_W'(NODE_CAP)) begin
                    dropped_next = ST_FULL;
                    status_next  = ST_FULL;
                end else begin
                    g_we            = 1'b1;
                    g_waddr         = {ins_reg, sym_reg};
                    g_wdata         = node_total_reg[NODE_W-1:0];
                    ins_next        = node_total_reg[NODE_W-1:0];
                    node_total_next = add_sum;
                end
            end

            // pattern end: saturating bump of end count
            S_PE_RD: begin
                e_raddr    = ins_reg;
                state_next = S_PE_WR;
            end
            S_PE_WR: begin
                add_req.a   = TOTAL_W'(e_rdata);
                add_req.b   = TOTAL_W'(1);
                add_req.sat = 1'b1;
                e_we        = 1'b1;
                e_waddr     = ins_reg;
                e_wdata     = add_sum[COUNT_W-1:0];
                ins_next    = '0;
                state_next  = S_RESP;
            end

            // build: per symbol, read own edge then fallback edge
            S_B_RD: begin
                g_raddr    = {node_reg, c_reg};
                state_next = S_B_RC;
            end
            S_B_RC: begin
                child_next = g_rdata;
                g_raddr    = {back_reg, c_reg};
                state_next = S_B_RB;
            end
            S_B_RB: begin
                add_req.a   = tail_reg;
                add_req.b   = TOTAL_W'(1);
                add_req.sat = 1'b0;
                if (child_reg == '0) begin
                    g_we    = 1'b1;
                    g_waddr = {node_reg, c_reg};
                    g_wdata = g_rdata;
                end else begin
                    f_we      = 1'b1;
                    f_waddr   = child_reg;
                    f_wdata   = root_reg ? '0 : g_rdata;
                    q_we      = 1'b1;
                    q_waddr   = tail_reg[NODE_W-1:0];
                    q_wdata   = child_reg;
                    tail_next = add_sum;
                end
                if (c_reg == SYM_W'(ALPHA - 1)) begin
                    root_next  = 1'b0;
                    state_next = S_B_POP;
                end else begin
                    c_next     = c_reg + 1'b1;
                    state_next = S_B_RD;
                end
            end
            S_B_POP: begin
                q_raddr = head_reg[NODE_W-1:0];
                if (head_reg == tail_reg) begin
                    built_next   = 1'b1;
                    ins_next     = '0;
                    dropped_next = ST_OK;
                    state_next   = S_RESP;
                end else begin
                    state_next = S_B_NODE;
                end
            end
            S_B_NODE: begin
                add_req.a   = head_reg;
                add_req.b   = TOTAL_W'(1);
                add_req.sat = 1'b0;
                head_next   = add_sum;
                node_next   = q_rdata;
                f_raddr     = q_rdata;
                state_next  = S_B_BACK;
            end
            S_B_BACK: begin
                back_next  = f_rdata;
                c_next     = '0;
                state_next = S_B_RD;
            end

            // text char: step, then walk unvisited failure chain
            S_T_RD: begin
                g_raddr    = {cur_reg, sym_reg};
                state_next = S_T_NXT;
            end
            S_T_NXT: begin
                cur_next   = g_rdata;
                j_next     = g_rdata;
                state_next = S_T_CHK;
            end
            S_T_CHK: begin
                v_raddr = j_reg;
                e_raddr = j_reg;
                f_raddr = j_reg;
                state_next = (j_reg == '0) ? S_RESP : S_T_EVAL;
            end
            S_T_EVAL: begin
                add_req.a   = TOTAL_W'(hit_reg);
                add_req.b   = TOTAL_W'(e_rdata);
                add_req.sat = 1'b1;
                if (v_rdata) begin
                    state_next = S_RESP;
                end else begin
                    hit_next   = add_sum[COUNT_W-1:0];
                    v_we       = 1'b1;
                    v_waddr    = j_reg;
                    v_wdata    = 1'b1;
                    j_next     = f_rdata;
                    state_next = S_T_CHK;
                end
            end

            // hand result to output register
            S_RESP: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {status_reg, hit_reg};
                    if (vclr_reg) begin
                        hit_next   = '0;
                        cur_next   = '0;
                        clr_next   = '0;
                        state_next = S_VCLR;
                    end else begin
                        state_next = S_IDLE;
                    end
                end
            end

            // clear visited marks between texts
            S_VCLR: begin
                v_we     = 1'b1;
                v_waddr  = clr_reg[NODE_W-1:0];
                clr_next = clr_reg + 1'b1;
                if (&clr_reg[NODE_W-1:0]) begin
                    state_next = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_CLEAR;
            clr_reg        <= '0;
            node_total_reg <= TOTAL_W'(1);
            ins_reg        <= '0;
            dropped_reg    <= ST_OK;
            built_reg      <= 1'b0;
            cur_reg        <= '0;
            hit_reg        <= '0;
            vclr_reg       <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            clr_reg        <= clr_next;
            node_total_reg <= node_total_next;
            ins_reg        <= ins_next;
            dropped_reg    <= dropped_next;
            built_reg      <= built_next;
            cur_reg        <= cur_next;
            hit_reg        <= hit_next;
            vclr_reg       <= vclr_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    // payload and walk registers
    always_ff @(posedge aclk) begin
        sym_reg    <= sym_next;
        status_reg <= status_next;
        j_reg      <= j_next;
        node_reg   <= node_next;
        back_reg   <= back_next;
        child_reg  <= child_next;
        c_reg      <= c_next;
        root_reg   <= root_next;
        head_reg   <= head_next;
        tail_reg   <= tail_next;
        m_data_reg <= m_data_next;
    end

    // one word in flight at a time
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("word accepted while previous still in work");

    // node count stays within capacity and never drops below root
    a_node_total: assert property (@(posedge aclk) disable iff (!aresetn)
        (node_total_reg <= TOTAL_W'(NODE_CAP)) && (node_total_reg != '0))
        else $error("node_total out of range");

    // insertion point is always an allocated node
    a_ins_alloc: assert property (@(posedge aclk) disable iff (!aresetn)
        ins_reg < node_total_reg)
        else $error("insertion point beyond allocated nodes");

    // chain walk never evaluates the root
    a_walk_nonroot: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_T_EVAL) |-> (j_reg != '0))
        else $error("failure walk reached root evaluation");

endmodule
`default_nettype wire

FILE: rtl/core/acpc_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module acpc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

FILE: rtl/core/acpc_add.sv
// Shared adder: plain add, or add saturating at the count maximum.
// Depends on acpc_pkg.
`default_nettype none
module acpc_add
    import acpc_pkg::*;
(
    input  wire add_req_t           req,
    output logic [TOTAL_W-1:0]      sum
);

    logic [TOTAL_W:0] full;

    always_comb begin
        full = {1'b0, req.a} + {1'b0, req.b};
        if (req.sat && (full > (TOTAL_W+1)'({COUNT_W{1'b1}}))) begin
            sum = TOTAL_W'({COUNT_W{1'b1}});
        end else begin
            sum = full[TOTAL_W-1:0];
        end
    end

endmodule
`default_nettype wire
